// ----- rtl/irc_pkg.sv -----
// shared types, codes and crc helpers for the image receiver
package irc_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned OUT_DEPTH    = 3;
  localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT   = 32'hFFFFFFFF;
  localparam logic [15:0] CRC16_POLY   = 16'h1021;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_ABORT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INACTIVE     = 3'd1,
    ST_BAD_RANGE    = 3'd2,
    ST_OUT_OF_ORDER = 3'd3,
    ST_REPLAY_MISM  = 3'd4,
    ST_INCOMPLETE   = 3'd5,
    ST_CRC_MISM     = 3'd6,
    ST_BAD_SIZE     = 3'd7
  } status_e;

  typedef enum logic {
    CFG_IMAGE_SIZE   = 1'b0,
    CFG_EXPECTED_CRC = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] calculated_crc;
    logic [15:0] header_crc16;
    logic [16:0] written_count;
  } res_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (v[0] ? CRC32_POLY : 32'h0);
    end
    return v;
  endfunction

  // crc-16/xmodem, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h0};
    for (int k = 0; k < 8; k++) begin
      v = {v[14:0], 1'b0} ^ (v[15] ? CRC16_POLY : 16'h0);
    end
    return v;
  endfunction

endpackage

// ----- rtl/irc_in_if.sv -----
// input channel: one command or data byte per beat
interface irc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic [16:0] block_offset;
  logic [16:0] block_length;
  logic [15:0] byte_index;
  logic        last_in_block;

  modport source (output valid, cmd, data_byte, block_offset, block_length,
                  byte_index, last_in_block, input ready);
  modport sink (input valid, cmd, data_byte, block_offset, block_length,
                byte_index, last_in_block, output ready);
endinterface

// ----- rtl/irc_out_if.sv -----
// result channel: one status report per beat
interface irc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] calculated_crc;
  logic [15:0] header_crc16;
  logic [16:0] written_count;

  modport source (output valid, status, calculated_crc, header_crc16,
                  written_count, input ready);
  modport sink (input valid, status, calculated_crc, header_crc16,
                written_count, output ready);
endinterface

// ----- rtl/irc_cfg_if.sv -----
// configuration write channel
interface irc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/irc_store.sv -----
// image byte store, one write and one registered read port with write bypass
module irc_store #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic [7:0] byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // same-edge write and read of one address returns the new byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

// ----- rtl/irc_fifo.sv -----
// small result queue between the session logic and the result channel
module irc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  irc_pkg::res_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output irc_pkg::res_t data_o,
  output logic [1:0]    count_o
);
  import irc_pkg::*;

  localparam logic [1:0] LastSlot = 2'(OUT_DEPTH - 1);

  res_t       slot_q [OUT_DEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ----- rtl/image_receive_and_crc_verify.sv -----
// firmware image receive session with crc-32 checking and a reported crc-16/xmodem
// a result is offered once its item has passed the input register and been pushed into the result queue
// throughput: one item per cycle while the result queue has room; set by the session state update
// and the single registered read port of the image store
// reset: session, position, crcs, registers and result queue cleared at once;
// the image store is not cleared, no sweep, items are taken right after reset
module image_receive_and_crc_verify #(
  parameter int unsigned STORE_BYTES = 65536
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  irc_in_if.sink   in_ch,
  irc_out_if.source out_ch,
  irc_cfg_if.sink  cfg_ch
);
  import irc_pkg::*;

  localparam int unsigned AW       = $clog2(STORE_BYTES);
  localparam int unsigned MaxImage = STORE_BYTES - HEADER_BYTES;

  // input register
  logic        s1_v_q;
  cmd_e        s1_cmd_q;
  logic [7:0]  s1_data_q;
  logic [16:0] s1_off_q;
  logic [16:0] s1_len_q;
  logic [15:0] s1_idx_q;
  logic        s1_last_q;

  // session state
  logic        active_q, active_d;
  logic [16:0] np_q, np_d;
  logic [31:0] crc32_q, crc32_d;
  logic [15:0] crc16_q, crc16_d;
  status_e     be_q, be_d;
  logic        br_q, br_d;
  logic [15:0] size_q;
  logic [31:0] ecrc_q;
  logic [15:0] held_size_q, held_size_d;
  logic [31:0] held_crc_q, held_crc_d;

  logic        in_acc;
  logic [17:0] in_pos;
  logic [17:0] pos;
  logic [17:0] off_end;
  logic [16:0] room;
  logic [16:0] idx_next;
  logic [7:0]  rd_data;
  logic        wr_en;
  logic        res_v;
  res_t        res;
  logic        fifo_v;
  res_t        fifo_data;
  logic [1:0]  fifo_cnt;
  logic        pop;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_pos = {1'b0, in_ch.block_offset} + {2'b0, in_ch.byte_index};

  // room in the queue for the item in flight and one more
  assign in_ch.ready  = ({1'b0, fifo_cnt} + {2'b0, s1_v_q}) < 3'(OUT_DEPTH);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= cmd_e'(in_ch.cmd);
      s1_data_q <= in_ch.data_byte;
      s1_off_q  <= in_ch.block_offset;
      s1_len_q  <= in_ch.block_length;
      s1_idx_q  <= in_ch.byte_index;
      s1_last_q <= in_ch.last_in_block;
    end
  end

  irc_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(pos)),
    .wr_data_i (s1_data_q),
    .rd_addr_i (AW'(in_pos)),
    .rd_data_o (rd_data)
  );

  always_comb begin
    active_d    = active_q;
    np_d        = np_q;
    crc32_d     = crc32_q;
    crc16_d     = crc16_q;
    be_d        = be_q;
    br_d        = br_q;
    held_size_d = held_size_q;
    held_crc_d  = held_crc_q;
    wr_en       = 1'b0;
    res_v       = 1'b0;
    res         = '0;
    pos         = {1'b0, s1_off_q} + {2'b0, s1_idx_q};
    off_end     = {1'b0, s1_off_q} + {1'b0, s1_len_q};
    room        = {1'b0, held_size_q} - s1_off_q;
    idx_next    = {1'b0, s1_idx_q} + 17'd1;

    if (s1_v_q) begin
      case (s1_cmd_q)
        CMD_BEGIN: begin
          res_v = 1'b1;
          if (size_q == 16'd0 || 32'(size_q) > MaxImage) begin
            res.status = ST_BAD_SIZE;
          end else begin
            held_size_d = size_q;
            held_crc_d  = ecrc_q;
            np_d        = 17'd0;
            crc32_d     = CRC32_INIT;
            crc16_d     = 16'h0;
            be_d        = ST_OUT_OF_ORDER;
            br_d        = 1'b0;
            active_d    = 1'b1;
          end
        end
        CMD_DATA: begin
          res_v = s1_last_q;
          if (active_q) begin
            // block check on the opening byte
            if (s1_idx_q == 16'd0) begin
              br_d = 1'b0;
              be_d = ST_OK;
              if (s1_len_q == 17'd0 || s1_off_q > {1'b0, held_size_q} ||
                  s1_len_q > room) begin
                be_d = ST_BAD_RANGE;
              end else if (s1_off_q < np_q) begin
                if (off_end > {1'b0, np_q}) begin
                  be_d = ST_OUT_OF_ORDER;
                end else begin
                  br_d = 1'b1;
                end
              end else if (s1_off_q != np_q) begin
                be_d = ST_OUT_OF_ORDER;
              end
            end
            if (be_d == ST_OK) begin
              if ({1'b0, s1_idx_q} >= s1_len_q || pos >= {2'b0, held_size_q}) begin
                be_d = ST_BAD_RANGE;
              end else if (br_d) begin
                if (pos >= {1'b0, np_q}) begin
                  be_d = ST_OUT_OF_ORDER;
                end else if (rd_data != s1_data_q) begin
                  be_d = ST_REPLAY_MISM;
                end
              end else if (pos != {1'b0, np_q}) begin
                be_d = ST_OUT_OF_ORDER;
              end else begin
                wr_en   = 1'b1;
                crc32_d = crc32_byte(crc32_q, s1_data_q);
                crc16_d = crc16_byte(crc16_q, s1_data_q);
                np_d    = np_q + 17'd1;
              end
            end
            // short block
            if (s1_last_q && be_d == ST_OK && idx_next != s1_len_q) begin
              be_d = ST_BAD_RANGE;
            end
          end
          if (s1_last_q) begin
            if (!active_q) begin
              res.status = ST_INACTIVE;
            end else begin
              res.status = be_d;
              be_d       = ST_OUT_OF_ORDER;
              br_d       = 1'b0;
            end
          end
        end
        CMD_FINISH: begin
          res_v = 1'b1;
          if (!active_q) begin
            res.status = ST_INACTIVE;
          end else if (np_q != {1'b0, held_size_q}) begin
            res.status = ST_INCOMPLETE;
          end else begin
            res.calculated_crc = ~crc32_q;
            res.header_crc16   = crc16_q;
            if (~crc32_q != held_crc_q) begin
              res.status = ST_CRC_MISM;
            end else begin
              active_d = 1'b0;
            end
          end
        end
        CMD_ABORT: begin
          res_v       = 1'b1;
          active_d    = 1'b0;
          np_d        = 17'd0;
          crc32_d     = CRC32_INIT;
          crc16_d     = 16'h0;
          be_d        = ST_OUT_OF_ORDER;
          br_d        = 1'b0;
          held_size_d = 16'h0;
          held_crc_d  = 32'h0;
        end
        default: begin
          res_v = 1'b0;
        end
      endcase
    end
    res.written_count = np_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      np_q        <= 17'd0;
      crc32_q     <= CRC32_INIT;
      crc16_q     <= 16'h0;
      be_q        <= ST_OK;
      br_q        <= 1'b0;
      size_q      <= 16'h0;
      ecrc_q      <= 32'h0;
      held_size_q <= 16'h0;
      held_crc_q  <= 32'h0;
    end else begin
      active_q    <= active_d;
      np_q        <= np_d;
      crc32_q     <= crc32_d;
      crc16_q     <= crc16_d;
      be_q        <= be_d;
      br_q        <= br_d;
      held_size_q <= held_size_d;
      held_crc_q  <= held_crc_d;
      if (cfg_ch.valid) begin
        case (cfg_idx_e'(cfg_ch.index))
          CFG_IMAGE_SIZE:   size_q <= cfg_ch.data[15:0];
          CFG_EXPECTED_CRC: ecrc_q <= cfg_ch.data;
          default:          size_q <= size_q;
        endcase
      end
    end
  end

  assign pop = fifo_v && out_ch.ready;

  irc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_v_q && res_v),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (fifo_v),
    .data_o      (fifo_data),
    .count_o     (fifo_cnt)
  );

  assign out_ch.valid          = fifo_v;
  assign out_ch.status         = fifo_data.status;
  assign out_ch.calculated_crc = fifo_data.calculated_crc;
  assign out_ch.header_crc16   = fifo_data.header_crc16;
  assign out_ch.written_count  = fifo_data.written_count;

endmodule

// ----- bench/irc_check_pkg.sv -----
`timescale 1ns / 100ps
// item type and expected-report scoreboard for the image receiver bench
package irc_check_pkg;
  import irc_pkg::*;

  localparam int unsigned STORE_BYTES = 65536;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  data_byte;
    logic [16:0] block_offset;
    logic [16:0] block_length;
    logic [15:0] byte_index;
    logic        last_in_block;
  } rx_item_t;

  class image_rx_checker;
    bit [7:0]    image_copy [STORE_BYTES];
    bit          active;
    int unsigned next_pos;
    bit [31:0]   crc32_acc = CRC32_INIT;
    bit [15:0]   crc16_acc;
    status_e     blk_status = ST_OK;
    bit          blk_replay;
    bit [15:0]   size_reg;
    bit [31:0]   crc_reg;
    int unsigned held_size;
    bit [31:0]   held_crc;
    res_t        expected_reports[$];
    int          errors;

    // lsb-first feedback form of the reflected crc-32
    static function bit [31:0] crc32_next(bit [31:0] c, bit [7:0] d);
      bit fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c = c >> 1;
        if (fb) c = c ^ CRC32_POLY;
      end
      return c;
    endfunction

    // msb-first feedback form of crc-16/xmodem
    static function bit [15:0] crc16_next(bit [15:0] c, bit [7:0] d);
      bit fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ d[k];
        c = c << 1;
        if (fb) c = c ^ CRC16_POLY;
      end
      return c;
    endfunction

    static function bit [31:0] crc32_of(bit [7:0] bytes[]);
      bit [31:0] c;
      c = CRC32_INIT;
      foreach (bytes[i]) c = crc32_next(c, bytes[i]);
      return ~c;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [31:0] value);
      if (idx == CFG_IMAGE_SIZE) size_reg = value[15:0];
      else crc_reg = value;
    endfunction

    // one data byte while a session is open
    function void absorb_byte(bit [7:0] d, int unsigned off, int unsigned len,
                              int unsigned idx);
      int unsigned pos;
      if (idx == 0) begin
        blk_replay = 1'b0;
        blk_status = ST_OK;
        if (len == 0 || off > held_size || len > held_size - off) begin
          blk_status = ST_BAD_RANGE;
        end else if (off < next_pos) begin
          if (off + len > next_pos) blk_status = ST_OUT_OF_ORDER;
          else blk_replay = 1'b1;
        end else if (off != next_pos) begin
          blk_status = ST_OUT_OF_ORDER;
        end
      end
      if (blk_status != ST_OK) return;
      pos = off + idx;
      if (idx >= len || pos >= held_size || pos >= STORE_BYTES) begin
        blk_status = ST_BAD_RANGE;
        return;
      end
      if (blk_replay) begin
        if (pos >= next_pos) blk_status = ST_OUT_OF_ORDER;
        else if (image_copy[pos] != d) blk_status = ST_REPLAY_MISM;
        return;
      end
      if (pos != next_pos) begin
        blk_status = ST_OUT_OF_ORDER;
        return;
      end
      image_copy[pos] = d;
      crc32_acc = crc32_next(crc32_acc, d);
      crc16_acc = crc16_next(crc16_acc, d);
      next_pos = (next_pos + 1) & 32'h1FFFF;
    endfunction

    function void clear_session();
      next_pos   = 0;
      crc32_acc  = CRC32_INIT;
      crc16_acc  = '0;
      blk_status = ST_OUT_OF_ORDER;
      blk_replay = 1'b0;
    endfunction

    function void note_item(rx_item_t it);
      res_t r;
      r.status         = ST_OK;
      r.calculated_crc = '0;
      r.header_crc16   = '0;
      case (it.cmd)
        CMD_BEGIN: begin
          if (size_reg == 0 || size_reg > STORE_BYTES - HEADER_BYTES) begin
            r.status = ST_BAD_SIZE;
          end else begin
            // replays only read bytes written in this session, no erase needed
            held_size = size_reg;
            held_crc  = crc_reg;
            clear_session();
            active = 1'b1;
          end
        end
        CMD_DATA: begin
          if (active) begin
            absorb_byte(it.data_byte, it.block_offset, it.block_length, it.byte_index);
            if (it.last_in_block && blk_status == ST_OK &&
                int'(it.byte_index) + 1 != int'(it.block_length)) begin
              blk_status = ST_BAD_RANGE;
            end
          end
          if (!it.last_in_block) return;
          if (!active) begin
            r.status = ST_INACTIVE;
          end else begin
            r.status   = blk_status;
            blk_status = ST_OUT_OF_ORDER;
            blk_replay = 1'b0;
          end
        end
        CMD_FINISH: begin
          if (!active) begin
            r.status = ST_INACTIVE;
          end else if (next_pos != held_size) begin
            r.status = ST_INCOMPLETE;
          end else begin
            r.calculated_crc = ~crc32_acc;
            r.header_crc16   = crc16_acc;
            if (r.calculated_crc != held_crc) r.status = ST_CRC_MISM;
            else active = 1'b0;
          end
        end
        default: begin
          active = 1'b0;
          clear_session();
          held_size = 0;
          held_crc  = '0;
        end
      endcase
      r.written_count = next_pos[16:0];
      expected_reports.push_back(r);
    endfunction

    function void report_bad(string what, res_t exp, res_t got);
      string exp_txt;
      string got_txt;
      errors++;
      if (errors <= 10) begin
        exp_txt = $sformatf("status %0d crc %08h crc16 %04h count %0d", exp.status,
                            exp.calculated_crc, exp.header_crc16, exp.written_count);
        got_txt = $sformatf("status %0d crc %08h crc16 %04h count %0d", got.status,
                            got.calculated_crc, got.header_crc16, got.written_count);
        $display("%s: expected %s, got %s", what, exp_txt, got_txt);
      end
    endfunction

    function void check_report(res_t got);
      res_t exp;
      if (expected_reports.size() == 0) begin
        exp = '0;
        report_bad("report with none pending", exp, got);
        return;
      end
      exp = expected_reports.pop_front();
      if (got.status !== exp.status || got.calculated_crc !== exp.calculated_crc ||
          got.header_crc16 !== exp.header_crc16 ||
          got.written_count !== exp.written_count) begin
        report_bad("report differs", exp, got);
      end
    endfunction
  endclass

endpackage

// ----- bench/image_receive_and_crc_verify_test.sv -----
`timescale 1ns / 100ps
// top of the image receiver bench: clock, reset, drivers and test sequence
module image_receive_and_crc_verify_test;
  import irc_pkg::*;
  import irc_check_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  irc_in_if  in_if ();
  irc_out_if out_if ();
  irc_cfg_if cfg_if ();

  image_receive_and_crc_verify #(
    .STORE_BYTES(STORE_BYTES)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  image_rx_checker board = new();

  int          sender_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          session_no;
  bit [7:0]    image_bytes[];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void set_phase(int p);
    case (p)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endfunction

  function rx_item_t data_item(bit [7:0] d, int unsigned off, int unsigned len,
                               int unsigned idx, bit last);
    rx_item_t it;
    it.cmd           = CMD_DATA;
    it.data_byte     = d;
    it.block_offset  = off[16:0];
    it.block_length  = len[16:0];
    it.byte_index    = idx[15:0];
    it.last_in_block = last;
    return it;
  endfunction

  // command beat with junk in the byte fields
  function rx_item_t cmd_item(cmd_e c);
    rx_item_t it;
    it = data_item($urandom_range(255), $urandom_range(17'h1FFFF),
                   $urandom_range(17'h1FFFF), $urandom_range(16'hFFFF), $urandom_range(1));
    it.cmd = c;
    return it;
  endfunction

  function rx_item_t noise_item(bit ctrl);
    rx_item_t    it;
    int unsigned r;
    it = data_item($urandom_range(255),
                   $urandom_range(1) ? $urandom_range(150) : $urandom_range(17'h1FFFF),
                   $urandom_range(1) ? $urandom_range(16) : $urandom_range(17'h1FFFF),
                   ($urandom_range(4) < 3) ? $urandom_range(16) : $urandom_range(16'hFFFF),
                   $urandom_range(1));
    r = $urandom_range(99);
    if (r >= 88 && r < 94) it.cmd = CMD_FINISH;
    else if (ctrl && r >= 94 && r < 97) it.cmd = CMD_ABORT;
    else if (ctrl && r >= 97) it.cmd = CMD_BEGIN;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic drive_item(rx_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.cmd           = it.cmd;
    in_if.data_byte     = it.data_byte;
    in_if.block_offset  = it.block_offset;
    in_if.block_length  = it.block_length;
    in_if.byte_index    = it.byte_index;
    in_if.last_in_block = it.last_in_block;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [31:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (board.expected_reports.size() != 0) @(negedge clk);
  endtask

  // idle before register writes: non-last bytes may still be in flight
  task automatic settle();
    wait_drained();
    repeat (4) @(negedge clk);
  endtask

  task automatic send_block(int unsigned off, int unsigned len, int unsigned nbytes,
                            int flip);
    bit [7:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (off + i < image_bytes.size()) b = image_bytes[off + i];
      else b = $urandom_range(255);
      if (int'(i) == flip) b = b ^ 8'($urandom_range(1, 255));
      drive_item(data_item(b, off, len, i, i == nbytes - 1));
    end
  endtask

  task automatic directed();
    bit [31:0] crc_a5;
    settle();
    drive_item(cmd_item(CMD_FINISH));
    drive_item(data_item(8'h5A, 0, 1, 0, 1'b1));
    drive_item(data_item(8'h00, 0, 2, 0, 1'b0));
    drive_item(cmd_item(CMD_ABORT));
    settle();
    write_reg(CFG_IMAGE_SIZE, 32'h0);
    drive_item(cmd_item(CMD_BEGIN));
    settle();
    write_reg(CFG_IMAGE_SIZE, 32'd65531);
    drive_item(cmd_item(CMD_BEGIN));
    settle();
    write_reg(CFG_IMAGE_SIZE, 32'd65530);
    write_reg(CFG_EXPECTED_CRC, 32'hFFFF_FFFF);
    drive_item(cmd_item(CMD_BEGIN));
    drive_item(data_item(8'hFF, 17'h10000, 17'h10000, 0, 1'b1));
    // stray byte with no opening byte of its block
    drive_item(data_item(8'h00, 0, 17'h10000, 16'hFFFF, 1'b1));
    drive_item(data_item(8'h00, 0, 17'h10000, 0, 1'b1));
    drive_item(data_item(8'h00, 0, 2, 0, 1'b0));
    drive_item(data_item(8'hFF, 0, 2, 1, 1'b1));
    drive_item(cmd_item(CMD_FINISH));
    drive_item(data_item(8'h00, 0, 1, 0, 1'b1));
    drive_item(data_item(8'h00, 1, 1, 0, 1'b1));
    drive_item(data_item(8'h11, 5, 1, 0, 1'b1));
    drive_item(data_item(8'h11, 1, 3, 0, 1'b1));
    // early last flag on a block of three
    drive_item(data_item(8'h22, 2, 3, 0, 1'b1));
    drive_item(data_item(8'h33, 3, 2, 0, 1'b0));
    drive_item(data_item(8'h44, 3, 2, 7, 1'b1));
    drive_item(cmd_item(CMD_ABORT));
    image_bytes = new[1];
    image_bytes[0] = 8'hA5;
    crc_a5 = image_rx_checker::crc32_of(image_bytes);
    settle();
    write_reg(CFG_IMAGE_SIZE, 32'hABCD_0001);
    write_reg(CFG_EXPECTED_CRC, crc_a5);
    drive_item(cmd_item(CMD_BEGIN));
    drive_item(data_item(8'hA5, 0, 1, 0, 1'b1));
    drive_item(cmd_item(CMD_FINISH));
    drive_item(cmd_item(CMD_FINISH));
    settle();
    write_reg(CFG_EXPECTED_CRC, ~crc_a5);
    drive_item(cmd_item(CMD_BEGIN));
    drive_item(data_item(8'hA5, 0, 1, 0, 1'b1));
    drive_item(cmd_item(CMD_FINISH));
    drive_item(cmd_item(CMD_FINISH));
    drive_item(cmd_item(CMD_ABORT));
  endtask

  task automatic run_session();
    int unsigned size, pos, off, len, nb, sent_bytes, pick, kind, room;
    bit [31:0]   good_crc;
    bit [15:0]   junk;
    bit          crc_right;
    kind = $urandom_range(99);
    if (kind < 70) size = $urandom_range(1, 24);
    else if (kind < 90) size = $urandom_range(25, 120);
    else if (kind < 95) begin
      case ($urandom_range(2))
        0: size = 0;
        1: size = 65531;
        default: size = 65535;
      endcase
    end else size = $urandom_range(1) ? 65530 : $urandom_range(4096, 65529);
    image_bytes = new[size];
    foreach (image_bytes[i]) image_bytes[i] = $urandom_range(255);
    good_crc  = image_rx_checker::crc32_of(image_bytes);
    crc_right = ($urandom_range(4) != 0);
    junk      = $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) : 16'h0;
    settle();
    write_reg(CFG_IMAGE_SIZE, {junk, size[15:0]});
    write_reg(CFG_EXPECTED_CRC, crc_right ? good_crc : $urandom);
    drive_item(cmd_item(CMD_BEGIN));
    if (size == 0 || size > STORE_BYTES - HEADER_BYTES) begin
      repeat ($urandom_range(1, 3)) drive_item(noise_item(1'b0));
      return;
    end
    pos = 0;
    sent_bytes = 0;
    while (pos < size && sent_bytes < 160) begin
      pick = $urandom_range(99);
      room = size - pos;
      if (pick < 70) begin
        len = $urandom_range(1, (room < 12) ? room : 12);
        send_block(pos, len, len, -1);
        pos += len;
        sent_bytes += len;
      end else if (pick < 78) begin
        // replay of bytes already written, sometimes with a corrupted byte
        if (pos > 0) begin
          off = $urandom_range(0, pos - 1);
          len = $urandom_range(1, pos - off);
          if (len > 12) len = 12;
          send_block(off, len, len, ($urandom_range(3) == 0) ? $urandom_range(len - 1) : -1);
          sent_bytes += len;
        end
      end else if (pick < 82) begin
        case ($urandom_range(3))
          0: send_block(pos, 0, $urandom_range(1, 2), -1);
          1: send_block(pos, room + $urandom_range(1, 3), 3, -1);
          2: send_block(pos + $urandom_range(1, 5), 2, 2, -1);
          default: send_block($urandom_range(17'h1FFFF), $urandom_range(17'h1FFFF), 2, -1);
        endcase
        sent_bytes += 2;
      end else if (pick < 86) begin
        // block cut short: bytes before the early last flag stay written
        if (room >= 2) begin
          len = $urandom_range(2, (room < 8) ? room : 8);
          nb  = $urandom_range(1, len - 1);
          send_block(pos, len, nb, -1);
          pos += nb;
          sent_bytes += nb;
        end
      end else if (pick < 89) begin
        drive_item(data_item($urandom_range(255), $urandom_range(17'h1FFFF),
                             $urandom_range(17'h1FFFF), $urandom_range(1, 16'hFFFF),
                             $urandom_range(1)));
      end else if (pick < 92) begin
        if (pos > 0) begin
          off = $urandom_range(0, pos - 1);
          send_block(off, pos - off + $urandom_range(1, 4), 2, -1);
        end
      end else if (pick < 94) begin
        drive_item(cmd_item(CMD_FINISH));
      end else if (pick < 96) begin
        if (room >= 2) begin
          len = $urandom_range(2, (room < 6) ? room : 6);
          drive_item(data_item(image_bytes[pos], pos, len, 0, 1'b0));
          drive_item(data_item($urandom_range(255), pos, len, len + $urandom_range(3), 1'b1));
          pos += 1;
          sent_bytes += 2;
        end
      end else if (pick < 97) begin
        wait_drained();
      end else if (pick < 98) begin
        drive_item(cmd_item(CMD_ABORT));
        return;
      end else begin
        drive_item(noise_item(1'b0));
      end
    end
    drive_item(cmd_item(CMD_FINISH));
    if ($urandom_range(3) == 0) drive_item(cmd_item(CMD_FINISH));
    if ((pos < size || !crc_right) && $urandom_range(1)) drive_item(cmd_item(CMD_ABORT));
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status         = status_e'(out_if.status);
      got.calculated_crc = out_if.calculated_crc;
      got.header_crc16   = out_if.header_crc16;
      got.written_count  = out_if.written_count;
      board.check_report(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_BEGIN;
    in_if.data_byte     = '0;
    in_if.block_offset  = '0;
    in_if.block_length  = '0;
    in_if.byte_index    = '0;
    in_if.last_in_block = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_IMAGE_SIZE;
    cfg_if.data         = '0;
    set_phase(0);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    directed();
    session_no = 0;
    while (items_sent < 730) begin
      set_phase(session_no % 4);
      run_session();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) drive_item(noise_item(1'b1));
      end
      session_no++;
    end
    wait_drained();
    repeat (20) @(negedge clk);
    if (board.expected_reports.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/irc_pkg.sv
rtl/irc_in_if.sv
rtl/irc_out_if.sv
rtl/irc_cfg_if.sv
rtl/irc_store.sv
rtl/irc_fifo.sv
rtl/image_receive_and_crc_verify.sv
bench/irc_check_pkg.sv
bench/image_receive_and_crc_verify_test.sv
